### src/cwk_pkg.sv
// Shared constants and types for the CW keyer with symbol queue.
// Has no dependencies. The top level cw_keyer_symbol_queue imports it.
`default_nettype none

package cwk_pkg;

    // Widths of the configuration register and the transaction payloads.
    localparam int DOT_W      = 14;
    localparam int SLOT_W     = 16;
    localparam int QUEUED_W   = 5;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 16;
    localparam int M_USED_W   = 10;

    // Defaults.
    localparam logic [DOT_W-1:0] DOT_TICKS_RESET     = 14'd200;
    localparam int               QUEUE_DEPTH_DEFAULT = 16;

    // Symbol codes held in the queue.
    localparam logic SYM_DASH = 1'b1;
    localparam logic SYM_DOT  = 1'b0;

    // One result transaction, last field in the lowest bit.
    typedef struct packed {
        logic                overflow;
        logic [QUEUED_W-1:0] queued;
        logic                tx_done;
        logic                symbol_start;
        logic                tone_on;
        logic                tx_active;
    } cwk_result_t;

endpackage

`default_nettype wire

### src/cw_keyer_symbol_queue.sv
// CW keyer: paddle edge capture, symbol queue and symbol timing.
// Depends on cwk_pkg for widths, defaults, symbol codes and the result type.
//
//  Channel   Direction  Payload (lowest bit first)
//  s_axis    in         sample_strobe, timer_tick, dash_pressed, dot_pressed
//  m_axis    out        tx_active, tone_on, symbol_start, tx_done, queued[4:0], overflow
//  cfg       in         dot_ticks[13:0]
//
// One result per input transaction appears in the output register on the next
// cycle. The input side stays ready while the output register is empty or
// being drained, so a new transaction is taken each cycle under no
// backpressure. aresetn is synchronous and active low; it empties the queue
// and stops transmission, and both input channels hold ready low while it is
// asserted. Configuration writes are taken in any cycle out of reset.
`default_nettype none

module cw_keyer_symbol_queue
    import cwk_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    // Input transactions
    input  wire                  s_tvalid,
    output logic                 s_tready,
    // [0] sample_strobe, [1] timer_tick, [2] dash_pressed, [3] dot_pressed
    input  wire [S_TDATA_W-1:0]  s_tdata,
    // Result transactions
    output logic                 m_tvalid,
    input  wire                  m_tready,
    // [0] tx_active, [1] tone_on, [2] symbol_start, [3] tx_done,
    // [8:4] queued, [9] overflow, rest zero
    output logic [M_TDATA_W-1:0] m_tdata,
    // Configuration write channel
    input  wire                  cfg_valid,
    output logic                 cfg_ready,
    input  wire [DOT_W-1:0]      cfg_data
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(QUEUE_DEPTH);

    // State registers
    logic [DOT_W-1:0]       dot_ticks_reg;
    logic                   dash_held_reg, dash_held_next;
    logic                   dot_held_reg, dot_held_next;
    logic [QUEUE_DEPTH-1:0] fifo_reg, fifo_next;
    logic [PTR_W-1:0]       head_reg, head_next;
    logic [PTR_W-1:0]       tail_reg, tail_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   sending_reg, sending_next;
    logic                   gate_reg, gate_next;
    logic                   is_dash_reg, is_dash_next;
    logic [SLOT_W-1:0]      slot_reg, slot_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]   m_tdata_reg, m_tdata_next;

    // Working values of the single-pass update
    logic              accept;
    logic              in_sample, in_tick, in_dash, in_dot;
    logic              start_v, done_v, ovf_v, pop_v;
    logic [SLOT_W-1:0] slot_inc, tone_len, slot_len;
    cwk_result_t       result;

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = aresetn && (!m_tvalid_reg || m_tready);
    assign cfg_ready = aresetn;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    assign in_sample = s_tdata[0];
    assign in_tick   = s_tdata[1];
    assign in_dash   = s_tdata[2];
    assign in_dot    = s_tdata[3];

    // Tone and slot lengths of the running symbol: dash 3 of 4 units, dot 1 of 2.
    assign slot_inc = slot_reg + SLOT_W'(1);
    always_comb begin
        if (is_dash_reg == SYM_DASH) begin
            tone_len = {2'b00, dot_ticks_reg} + {1'b0, dot_ticks_reg, 1'b0};
            slot_len = {dot_ticks_reg, 2'b00};
        end else begin
            tone_len = {2'b00, dot_ticks_reg};
            slot_len = {1'b0, dot_ticks_reg, 1'b0};
        end
    end

    // One tick: paddle sample, timer step, then start from idle.
    always_comb begin
        dash_held_next = dash_held_reg;
        dot_held_next  = dot_held_reg;
        fifo_next      = fifo_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        sending_next   = sending_reg;
        gate_next      = gate_reg;
        is_dash_next   = is_dash_reg;
        slot_next      = slot_reg;
        start_v        = 1'b0;
        done_v         = 1'b0;
        ovf_v          = 1'b0;
        pop_v          = 1'b0;

        if (accept) begin
            // Dash paddle: release after a press queues a dash.
            if (in_sample) begin
                if (in_dash) begin
                    dash_held_next = 1'b1;
                end else if (dash_held_reg) begin
                    dash_held_next = 1'b0;
                    if (count_next == FULL_CNT) begin
                        ovf_v = 1'b1;
                    end else begin
                        fifo_next[tail_next] = SYM_DASH;
                        tail_next  = (tail_next == LAST_PTR) ? '0 : tail_next + PTR_W'(1);
                        count_next = count_next + CNT_W'(1);
                    end
                end
                // Dot paddle, after the dash.
                if (in_dot) begin
                    dot_held_next = 1'b1;
                end else if (dot_held_reg) begin
                    dot_held_next = 1'b0;
                    if (count_next == FULL_CNT) begin
                        ovf_v = 1'b1;
                    end else begin
                        fifo_next[tail_next] = SYM_DOT;
                        tail_next  = (tail_next == LAST_PTR) ? '0 : tail_next + PTR_W'(1);
                        count_next = count_next + CNT_W'(1);
                    end
                end
            end

            // Timer step of the running symbol.
            if (sending_reg && in_tick) begin
                slot_next = slot_inc;
                if (slot_inc >= slot_len) begin
                    slot_next = '0;
                    if (count_next != '0) begin
                        pop_v = 1'b1;
                    end else begin
                        sending_next = 1'b0;
                        gate_next    = 1'b0;
                        done_v       = 1'b1;
                    end
                end else if (slot_inc >= tone_len) begin
                    gate_next = 1'b0;
                end
            end

            // Start from idle.
            if (!sending_next && count_next != '0) begin
                sending_next = 1'b1;
                pop_v        = 1'b1;
            end

            // At most one pop per tick; it sees symbols queued this tick.
            if (pop_v) begin
                is_dash_next = fifo_next[head_reg];
                head_next    = (head_reg == LAST_PTR) ? '0 : head_reg + PTR_W'(1);
                count_next   = count_next - CNT_W'(1);
                gate_next    = 1'b1;
                slot_next    = '0;
                start_v      = 1'b1;
            end
        end
    end

    // Result packing and output register handshake.
    always_comb begin
        result.tx_active    = sending_next;
        result.tone_on      = gate_next;
        result.symbol_start = start_v;
        result.tx_done      = done_v;
        result.queued       = QUEUED_W'(count_next);
        result.overflow     = ovf_v;

        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (accept) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {{(M_TDATA_W - M_USED_W){1'b0}}, result};
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    // Control state with reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dot_ticks_reg <= DOT_TICKS_RESET;
            dash_held_reg <= 1'b0;
            dot_held_reg  <= 1'b0;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            sending_reg   <= 1'b0;
            gate_reg      <= 1'b0;
            is_dash_reg   <= 1'b0;
            slot_reg      <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                dot_ticks_reg <= cfg_data;
            end
            dash_held_reg <= dash_held_next;
            dot_held_reg  <= dot_held_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            sending_reg   <= sending_next;
            gate_reg      <= gate_next;
            is_dash_reg   <= is_dash_next;
            slot_reg      <= slot_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    // Payload registers without reset.
    always_ff @(posedge aclk) begin
        fifo_reg    <= fifo_next;
        m_tdata_reg <= m_tdata_next;
    end

    // The queue never holds more than its depth.
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL_CNT)
        else $error("symbol queue count above depth");

    // An idle transmitter always has an empty queue.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !sending_reg |-> count_reg == '0)
        else $error("queue holds symbols while transmitter idle");

    // The tone gate is only open while transmitting.
    assert property (@(posedge aclk) disable iff (!aresetn)
        gate_reg |-> sending_reg)
        else $error("tone gate open while not transmitting");

    // A result never reports both a symbol start and the end of transmission.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> !(m_tdata_reg[2] && m_tdata_reg[3]))
        else $error("symbol start and tx done in the same result");

endmodule

`default_nettype wire
